/* design/hcbd_pkg.sv */
// Shared types and constants of the chunked HTTP body deframer.
package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int EXT_W         = 12;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [EXT_W-1:0] EXT_LIMIT_RESET = 12'd512;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Register index decoded from paddr above the byte offset.
    typedef enum logic [0:0] {
        REG_EXT_LIMIT = 1'b0
    } t_reg_idx;

    typedef enum logic [5:0] {
        MODE_SIZE    = 6'b000001,
        MODE_EXT     = 6'b000010,
        MODE_DATA    = 6'b000100,
        MODE_AFTER   = 6'b001000,
        MODE_TRAILER = 6'b010000,
        MODE_ERROR   = 6'b100000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_SIZE_CHAR = 2'd1,
        CAUSE_EXT_LONG  = 2'd2,
        CAUSE_AFTER     = 2'd3
    } t_cause;

    typedef struct packed {
        t_mode            mode;
        logic [EXT_W-1:0] ext_count;
        logic             line_start;
    } t_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        t_kind      kind;
        t_cause     cause;
    } t_result;

endpackage

/* design/hcbd_if.sv */
// Request and response channel interfaces of the chunked HTTP body deframer.
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_cause;

    modport source (output valid, output out_byte, output kind, output error_cause,
                    input ready);
    modport sink (input valid, input out_byte, input kind, input error_cause,
                  output ready);
endinterface

/* design/hcbd_step.sv */
// Next-state and result logic for one body byte of the chunked deframer.
module hcbd_step
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic [7:0]           i_byte,
    input  t_ctl                 i_ctl,
    input  logic [SIZE_BITS-1:0] i_rem,
    input  logic [EXT_W-1:0]     i_limit,
    output t_ctl                 o_ctl,
    output logic [SIZE_BITS-1:0] o_rem,
    output t_result              o_res
);

    logic                 is_hex;
    logic [3:0]           hex_val;
    logic [SIZE_BITS-1:0] rem_dec;

    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (i_byte inside {["0":"9"]}) begin
            hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte inside {["a":"f"]}) begin
            hex_val = 4'(i_byte - 8'h57);
        end else if (i_byte inside {["A":"F"]}) begin
            hex_val = 4'(i_byte - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign rem_dec = i_rem - SIZE_BITS'(1);

    always_comb begin
        o_ctl          = i_ctl;
        o_rem          = i_rem;
        o_res.valid    = 1'b0;
        o_res.out_byte = 8'd0;
        o_res.kind     = KIND_PAYLOAD;
        o_res.cause    = CAUSE_NONE;

        case (i_ctl.mode)
            MODE_SIZE: begin
                if (is_hex) begin
                    // A nonzero top digit would be shifted out of the size field.
                    if (i_rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                        o_ctl.mode  = MODE_ERROR;
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_ERROR;
                        o_res.cause = CAUSE_AFTER;
                    end else begin
                        o_rem = {i_rem[SIZE_BITS-5:0], hex_val};
                    end
                end else if (i_byte == CH_LF) begin
                    if (i_rem == '0) begin
                        o_ctl.mode       = MODE_TRAILER;
                        o_ctl.line_start = 1'b1;
                    end else begin
                        o_ctl.mode = MODE_DATA;
                    end
                end else if (i_byte == CH_CR || i_byte == CH_SPACE) begin
                    o_ctl.mode = MODE_SIZE;
                end else if (i_byte == CH_SEMI) begin
                    o_ctl.mode      = MODE_EXT;
                    o_ctl.ext_count = '0;
                end else begin
                    o_ctl.mode  = MODE_ERROR;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.cause = CAUSE_SIZE_CHAR;
                end
            end
            MODE_EXT: begin
                if (i_byte == CH_LF) begin
                    if (i_rem == '0) begin
                        o_ctl.mode       = MODE_TRAILER;
                        o_ctl.line_start = 1'b1;
                    end else begin
                        o_ctl.mode = MODE_DATA;
                    end
                end else if (i_ctl.ext_count >= i_limit) begin
                    o_ctl.mode  = MODE_ERROR;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.cause = CAUSE_EXT_LONG;
                end else begin
                    o_ctl.ext_count = i_ctl.ext_count + EXT_W'(1);
                end
            end
            MODE_DATA: begin
                o_rem          = rem_dec;
                o_res.valid    = 1'b1;
                o_res.out_byte = i_byte;
                if (rem_dec == '0) begin
                    o_ctl.mode = MODE_AFTER;
                end
            end
            MODE_AFTER: begin
                if (i_byte == CH_LF) begin
                    o_ctl.mode = MODE_SIZE;
                    o_rem      = '0;
                end else if (i_byte != CH_CR) begin
                    o_ctl.mode  = MODE_ERROR;
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    o_res.cause = CAUSE_AFTER;
                end
            end
            MODE_TRAILER: begin
                if (i_byte == CH_LF) begin
                    o_ctl.line_start = 1'b1;
                    if (i_ctl.line_start) begin
                        // An empty line closes the message.
                        o_ctl.mode      = MODE_SIZE;
                        o_ctl.ext_count = '0;
                        o_rem           = '0;
                        o_res.valid     = 1'b1;
                        o_res.kind      = KIND_COMPLETE;
                    end
                end else if (i_byte != CH_CR) begin
                    o_ctl.line_start = 1'b0;
                end
            end
            default: begin
                o_ctl.mode = MODE_ERROR;
            end
        endcase
    end

endmodule

/* design/http_chunked_body_deframer_top.sv */
// Top level of the chunked HTTP body deframer: channels, registers and config port.
//
// This block takes the body of a chunked HTTP response one byte per request and
// returns payload bytes, a message-complete marker after the trailer's empty line,
// and a single framing error result when the stream is malformed; after an error
// the block stays silent until reset. It sustains one byte per clock cycle while
// its results are taken downstream: a byte is registered at the input, decoded
// against the parse state in combinational logic, and its result (if any) is
// registered in the output register when the decode stage advances. The single
// output register sets the rate: a new byte is taken whenever the input register
// is empty or its byte can move on, which it can while the output register is
// empty or being taken downstream. Bytes that cause no result (size digits, CR,
// extension text) still pass through the decode stage, which waits on that same
// condition. The extension_limit register sits at byte address 0 of the APB
// port and must only be written while the block is idle. SIZE_BITS sets the
// largest chunk size that is accepted; a size line with more significant digits
// than that is reported as a framing error.
module http_chunked_body_deframer_top
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hcbd_in_if.sink            i_req,
    hcbd_out_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Input stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parse state.
    t_ctl                 r_ctl;
    logic [SIZE_BITS-1:0] r_rem;
    logic [EXT_W-1:0]     r_limit;

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_kind      r_out_kind;
    t_cause     r_out_cause;

    t_ctl                 n_ctl;
    logic [SIZE_BITS-1:0] n_rem;
    t_result              n_res;

    logic advance;
    logic in_fire;
    logic cfg_write;
    logic reg_hit;

    // The decode stage moves on when the result slot is free or being emptied.
    assign advance = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign in_fire = i_req.valid && i_req.ready;

    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_byte  (r_in_byte),
        .i_ctl   (r_ctl),
        .i_rem   (r_rem),
        .i_limit (r_limit),
        .o_ctl   (n_ctl),
        .o_rem   (n_rem),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_req.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.mode       <= MODE_SIZE;
            r_ctl.ext_count  <= '0;
            r_ctl.line_start <= 1'b1;
            r_rem            <= '0;
        end else if (r_in_valid && advance) begin
            r_ctl <= n_ctl;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance && n_res.valid) begin
            r_out_byte  <= n_res.out_byte;
            r_out_kind  <= n_res.kind;
            r_out_cause <= n_res.cause;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_byte    = r_out_byte;
    assign o_rsp.kind        = r_out_kind;
    assign o_rsp.error_cause = r_out_cause;

    // Configuration port: the register index is the address above the byte offset.
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[PADDR_W-1:2] == REG_EXT_LIMIT);
    assign cfg_write = psel && penable && pwrite && reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= EXT_LIMIT_RESET;
        end else if (cfg_write) begin
            r_limit <= pwdata[EXT_W-1:0];
        end
    end

    assign prdata = reg_hit ? PDATA_W'(r_limit) : '0;

    // Once in error mode, the parser never leaves it until reset.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode == MODE_ERROR) |=> (r_ctl.mode == MODE_ERROR))
        else $error("parser left error mode without reset");

    // Data mode always has at least one byte of the chunk left.
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode == MODE_DATA) |-> (r_rem != '0))
        else $error("data mode with empty chunk count");

    // A pending error result implies the parser is already in error mode.
    a_error_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_ERROR) |-> (r_ctl.mode == MODE_ERROR))
        else $error("error result without error mode");

    // Error results always carry a cause, other results never do.
    a_cause_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_kind == KIND_ERROR) == (r_out_cause != CAUSE_NONE)))
        else $error("error cause does not match result kind");

endmodule
